@@ hdl/tdist_pkg.sv @@
`timescale 1ns / 1ps

package tdist_pkg;

    localparam int TORQUE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int NUM_TENDON = 3;
    localparam int FRAC_BITS  = 12;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int SAT_W      = 36;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COEF_ROW_0     = 3'd0,
        REG_COEF_ROW_1     = 3'd1,
        REG_COEF_ROW_2     = 3'd2,
        REG_PULLEY_RADIUS  = 3'd3,
        REG_MIN_TORQUE     = 3'd4,
        REG_TORQUE_CEILING = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] joint_torque_a;
        logic signed [TORQUE_W-1:0] joint_torque_b;
    } joint_item_t;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] motor_torque_0;
        logic signed [TORQUE_W-1:0] motor_torque_1;
        logic signed [TORQUE_W-1:0] motor_torque_2;
        logic                       offset_applied;
    } motor_item_t;

    typedef struct packed {
        logic [NUM_TENDON-1:0][CFG_DATA_W-1:0] coef_row;
        logic [TORQUE_W-1:0]                   pulley_radius;
        logic signed [TORQUE_W-1:0]            min_torque;
        logic signed [TORQUE_W-1:0]            torque_ceiling;
    } cfg_t;

    // saturate to a signed value of w bits
    function automatic logic signed [SAT_W-1:0] sat_width(
        input logic signed [SAT_W-1:0] v,
        input int unsigned             w
    );
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = (SAT_W'(1) <<< (w - 1)) - SAT_W'(1);
        lo = -hi - SAT_W'(1);
        priority if (v > hi)
        begin
            return hi;
        end
        else if (v < lo)
        begin
            return lo;
        end
        else
        begin
            return v;
        end
    endfunction

endpackage

@@ hdl/tendon_torque_distribution.sv @@
`timescale 1ns / 1ps

// Tendon torque distribution: joint torque pair in, three motor torques out.
// Input channel joint_valid / joint_stall / joint_item carries two signed
// Q8.8 joint torques; output channel motor_valid / motor_stall / motor_item
// carries three clamped Q8.8 motor torques and the offset_applied flag.
// An item moves on a clock edge where valid is high and stall is low.
// Six register stages: coefficient products, rounded force sums, offset
// search, offset add, radius product, round and clamp. An item passes the
// stages in that order; one item per cycle is taken sustained while
// motor_stall is low.
// A stall from the output holds every occupied stage; empty stages still
// fill, so joint_stall rises only once all six stages hold items.
// No item is lost or repeated.
// Registers are written through cfg_we / cfg_index / cfg_data, one per
// cycle, and must only change while the pipeline is empty. Unknown indexes
// are ignored.
// Reset clears all pipeline valid bits and loads the register defaults:
// zero coefficients, radius 1.0, clamp range 0 to the largest positive value.

module tendon_torque_distribution
    import tdist_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   joint_valid,
    output logic                   joint_stall,
    input  joint_item_t            joint_item,
    output logic                   motor_valid,
    input  logic                   motor_stall,
    output motor_item_t            motor_item
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic                         frc_valid;
    logic                         frc_stall;
    logic signed [DATA_WIDTH-1:0] frc     [NUM_TENDON];
    logic                         adj_valid;
    logic                         adj_stall;
    logic signed [DATA_WIDTH-1:0] frc_adj [NUM_TENDON];
    logic                         offset_flag;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_ROW_0:     cfg_next.coef_row[0]    = cfg_data;
                REG_COEF_ROW_1:     cfg_next.coef_row[1]    = cfg_data;
                REG_COEF_ROW_2:     cfg_next.coef_row[2]    = cfg_data;
                REG_PULLEY_RADIUS:  cfg_next.pulley_radius  = cfg_data[TORQUE_W-1:0];
                REG_MIN_TORQUE:     cfg_next.min_torque     = cfg_data[TORQUE_W-1:0];
                REG_TORQUE_CEILING: cfg_next.torque_ceiling = cfg_data[TORQUE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_row       <= '0;
            cfg_reg.pulley_radius  <= TORQUE_W'(1 << FRAC_BITS);
            cfg_reg.min_torque     <= '0;
            cfg_reg.torque_ceiling <= {1'b0, {(TORQUE_W - 1){1'b1}}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tdist_force #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_force (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (joint_valid),
        .up_stall (joint_stall),
        .item     (joint_item),
        .dn_valid (frc_valid),
        .dn_stall (frc_stall),
        .frc      (frc)
    );

    tdist_offset #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_offset (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (frc_valid),
        .up_stall    (frc_stall),
        .frc         (frc),
        .dn_valid    (adj_valid),
        .dn_stall    (adj_stall),
        .frc_adj     (frc_adj),
        .offset_flag (offset_flag)
    );

    tdist_scale #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .up_valid    (adj_valid),
        .up_stall    (adj_stall),
        .frc_adj     (frc_adj),
        .offset_flag (offset_flag),
        .dn_valid    (motor_valid),
        .dn_stall    (motor_stall),
        .item        (motor_item)
    );

`ifndef SYNTHESIS
    // an open output leaves the whole pipeline open
    assert property (@(posedge clk) disable iff (!rst_n)
        !motor_stall |-> !joint_stall)
    else $error("joint_stall high while output is not stalled");

    // an accepted item reaches the output while the output does not stall
    assert property (@(posedge clk) disable iff (!rst_n)
        (joint_valid && !joint_stall) ##1 !motor_stall ##1 !motor_stall
        ##1 !motor_stall ##1 !motor_stall ##1 !motor_stall |=> motor_valid)
    else $error("item did not reach the output in six cycles");

    // results stay inside an ordered clamp range
    assert property (@(posedge clk) disable iff (!rst_n)
        (motor_valid && (cfg_reg.min_torque <= cfg_reg.torque_ceiling)) |->
        (motor_item.motor_torque_0 >= cfg_reg.min_torque
         && motor_item.motor_torque_0 <= cfg_reg.torque_ceiling
         && motor_item.motor_torque_1 >= cfg_reg.min_torque
         && motor_item.motor_torque_1 <= cfg_reg.torque_ceiling
         && motor_item.motor_torque_2 >= cfg_reg.min_torque
         && motor_item.motor_torque_2 <= cfg_reg.torque_ceiling))
    else $error("motor torque outside clamp range");
`endif

endmodule

@@ hdl/tdist_force.sv @@
`timescale 1ns / 1ps

module tdist_force
    import tdist_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         up_valid,
    output logic                         up_stall,
    input  joint_item_t                  item,
    output logic                         dn_valid,
    input  logic                         dn_stall,
    output logic signed [DATA_WIDTH-1:0] frc [NUM_TENDON]
);

    localparam int PROD_W = 2 * COEF_W;
    localparam int SUM_W  = PROD_W + 1;

    logic s1_en;
    logic s2_en;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;

    logic signed [PROD_W-1:0]     prod_reg  [NUM_TENDON][2];
    logic signed [PROD_W-1:0]     prod_next [NUM_TENDON][2];
    logic signed [SUM_W-1:0]      sum_rnd   [NUM_TENDON];
    logic signed [SUM_W-1:0]      sum_shift [NUM_TENDON];
    logic signed [SAT_W-1:0]      sum_sat   [NUM_TENDON];
    logic signed [DATA_WIDTH-1:0] frc_reg   [NUM_TENDON];
    logic signed [DATA_WIDTH-1:0] frc_next  [NUM_TENDON];

    assign s2_en    = !s2_valid_reg || !dn_stall;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign up_stall = !s1_en;

    assign s1_valid_next = s1_en ? up_valid : s1_valid_reg;
    assign s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_TENDON; i++)
        begin
            prod_next[i][0] = $signed(cfg.coef_row[i][COEF_W-1:0]) * item.joint_torque_a;
            prod_next[i][1] = $signed(cfg.coef_row[i][2*COEF_W-1:COEF_W])
                              * item.joint_torque_b;
            sum_rnd[i]   = SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1])
                           + SUM_W'(ROUND_HALF);
            sum_shift[i] = sum_rnd[i] >>> FRAC_BITS;
            sum_sat[i]   = sat_width(SAT_W'(sum_shift[i]), DATA_WIDTH);
            frc_next[i]  = sum_sat[i][DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && up_valid)
        begin
            prod_reg <= prod_next;
        end
        if (s2_en && s1_valid_reg)
        begin
            frc_reg <= frc_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign frc      = frc_reg;

endmodule

@@ hdl/tdist_offset.sv @@
`timescale 1ns / 1ps

module tdist_offset
    import tdist_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_stall,
    input  logic signed [DATA_WIDTH-1:0] frc [NUM_TENDON],
    output logic                         dn_valid,
    input  logic                         dn_stall,
    output logic signed [DATA_WIDTH-1:0] frc_adj [NUM_TENDON],
    output logic                         offset_flag
);

    localparam int AW = DATA_WIDTH + 1;

    logic s3_en;
    logic s4_en;
    logic s3_valid_reg;
    logic s3_valid_next;
    logic s4_valid_reg;
    logic s4_valid_next;

    logic signed [AW-1:0]         neg_f0;
    logic signed [AW-1:0]         neg_f1;
    logic signed [AW:0]           half_f2;
    logic signed [AW-1:0]         alpha_reg;
    logic signed [AW-1:0]         alpha_next;
    logic signed [DATA_WIDTH-1:0] frc_reg  [NUM_TENDON];
    logic signed [SAT_W-1:0]      adj_sum  [NUM_TENDON];
    logic signed [SAT_W-1:0]      adj_sat  [NUM_TENDON];
    logic signed [DATA_WIDTH-1:0] adj_reg  [NUM_TENDON];
    logic signed [DATA_WIDTH-1:0] adj_next [NUM_TENDON];
    logic                         flag_reg;
    logic                         flag_next;

    assign s4_en    = !s4_valid_reg || !dn_stall;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign up_stall = !s3_en;

    assign s3_valid_next = s3_en ? up_valid : s3_valid_reg;
    assign s4_valid_next = s4_en ? s3_valid_reg : s4_valid_reg;

    // smallest offset that brings every force to zero or above; force two gets twice
    always_comb
    begin
        neg_f0  = -AW'(frc[0]);
        neg_f1  = -AW'(frc[1]);
        half_f2 = ((-(AW + 1)'(frc[2])) + (AW + 1)'(1)) >>> 1;
        alpha_next = '0;
        if (neg_f0 > alpha_next)
        begin
            alpha_next = neg_f0;
        end
        if (neg_f1 > alpha_next)
        begin
            alpha_next = neg_f1;
        end
        if (frc[2] < 0 && half_f2[AW-1:0] > alpha_next)
        begin
            alpha_next = half_f2[AW-1:0];
        end
    end

    always_comb
    begin
        adj_sum[0] = SAT_W'(frc_reg[0]) + SAT_W'(alpha_reg);
        adj_sum[1] = SAT_W'(frc_reg[1]) + SAT_W'(alpha_reg);
        adj_sum[2] = SAT_W'(frc_reg[2]) + (SAT_W'(alpha_reg) <<< 1);
        for (int i = 0; i < NUM_TENDON; i++)
        begin
            adj_sat[i]  = sat_width(adj_sum[i], DATA_WIDTH);
            adj_next[i] = adj_sat[i][DATA_WIDTH-1:0];
        end
        flag_next = (alpha_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && up_valid)
        begin
            frc_reg   <= frc;
            alpha_reg <= alpha_next;
        end
        if (s4_en && s3_valid_reg)
        begin
            adj_reg  <= adj_next;
            flag_reg <= flag_next;
        end
    end

    assign dn_valid    = s4_valid_reg;
    assign frc_adj     = adj_reg;
    assign offset_flag = flag_reg;

endmodule

@@ hdl/tdist_scale.sv @@
`timescale 1ns / 1ps

module tdist_scale
    import tdist_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         up_valid,
    output logic                         up_stall,
    input  logic signed [DATA_WIDTH-1:0] frc_adj [NUM_TENDON],
    input  logic                         offset_flag,
    output logic                         dn_valid,
    input  logic                         dn_stall,
    output motor_item_t                  item
);

    localparam int PW = DATA_WIDTH + TORQUE_W + 1;
    localparam int RW = PW + 1;

    logic s5_en;
    logic s6_en;
    logic s5_valid_reg;
    logic s5_valid_next;
    logic s6_valid_reg;
    logic s6_valid_next;

    logic signed [PW-1:0]       prod_reg  [NUM_TENDON];
    logic signed [PW-1:0]       prod_next [NUM_TENDON];
    logic                       flag_reg;
    logic signed [RW-1:0]       scaled    [NUM_TENDON];
    logic signed [RW-1:0]       raised    [NUM_TENDON];
    logic signed [RW-1:0]       clamped   [NUM_TENDON];
    logic signed [RW-1:0]       lo_bound;
    logic signed [RW-1:0]       hi_bound;
    motor_item_t                item_reg;
    motor_item_t                item_next;

    assign s6_en    = !s6_valid_reg || !dn_stall;
    assign s5_en    = !s5_valid_reg || s6_en;
    assign up_stall = !s5_en;

    assign s5_valid_next = s5_en ? up_valid : s5_valid_reg;
    assign s6_valid_next = s6_en ? s5_valid_reg : s6_valid_reg;

    assign lo_bound = RW'(cfg.min_torque);
    assign hi_bound = RW'(cfg.torque_ceiling);

    always_comb
    begin
        for (int i = 0; i < NUM_TENDON; i++)
        begin
            prod_next[i] = PW'(frc_adj[i]) * PW'($signed({1'b0, cfg.pulley_radius}));
            scaled[i]    = (RW'(prod_reg[i]) + RW'(ROUND_HALF)) >>> FRAC_BITS;
            raised[i]    = (scaled[i] < lo_bound) ? lo_bound : scaled[i];
            clamped[i]   = (raised[i] > hi_bound) ? hi_bound : raised[i];
        end
        item_next.motor_torque_0 = clamped[0][TORQUE_W-1:0];
        item_next.motor_torque_1 = clamped[1][TORQUE_W-1:0];
        item_next.motor_torque_2 = clamped[2][TORQUE_W-1:0];
        item_next.offset_applied = flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s5_valid_next;
            s6_valid_reg <= s6_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_en && up_valid)
        begin
            prod_reg <= prod_next;
            flag_reg <= offset_flag;
        end
        if (s6_en && s5_valid_reg)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = s6_valid_reg;
    assign item     = item_reg;

endmodule
